// ===== hdl/tkws_pkg.sv =====
`timescale 1ns / 1ps

package tkws_pkg;

	localparam int DEF_LIST_DEPTH = 256;
	localparam int DEF_TAXA       = 64;

	localparam int LIMIT_W  = 9;
	localparam int WEIGHT_W = 32;
	localparam int SET_W    = 64;
	localparam int RANK_W   = 8;
	localparam int OCC_W    = 9;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// control bits that ride along with a beat as it walks the chain
	typedef struct packed {
		logic vld;    // beat present in this slot
		logic op;     // OP_INSERT or OP_READ
		logic fresh;  // carried entry is still the new one (insert)
		logic hit;    // insert: list overflows; read: rank below count
	} ctl_t;

endpackage

// ===== hdl/tkws_cell.sv =====
`timescale 1ns / 1ps

module tkws_cell import tkws_pkg::*; #(
	parameter int IDX  = 0,
	parameter int TAXA = DEF_TAXA,
	parameter int CW   = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl_i,
	input  logic [WEIGHT_W-1:0] wt_i,
	input  logic [TAXA-1:0]     set_i,
	input  logic [RANK_W-1:0]   rank_i,
	input  logic [CW-1:0]       cnt_i,
	output ctl_t                ctl_o,
	output logic [WEIGHT_W-1:0] wt_o,
	output logic [TAXA-1:0]     set_o,
	output logic [RANK_W-1:0]   rank_o,
	output logic [CW-1:0]       cnt_o
);

	logic [WEIGHT_W-1:0] wt_q;
	logic [TAXA-1:0]     set_q;
	logic                occupied;
	logic                in_range;
	logic                swap;
	logic                rd_hit;
	ctl_t                ctl_nxt;

	always_comb begin
		occupied = 32'(cnt_i) > 32'(IDX);
		// cells up to the new count take part; an overflowing insert stops one short
		in_range = (32'(cnt_i) + 32'(!ctl_i.hit)) > 32'(IDX);
		// once the new entry has settled, every later cell shifts down regardless of weight
		swap     = ctl_i.vld && (ctl_i.op == OP_INSERT) && in_range
		           && (!occupied || !ctl_i.fresh || (wt_i > wt_q));
		rd_hit   = ctl_i.vld && (ctl_i.op == OP_READ) && ctl_i.hit
		           && (32'(rank_i) == 32'(IDX));
		ctl_nxt       = ctl_i;
		ctl_nxt.fresh = ctl_i.fresh && !swap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		rank_o <= rank_i;
		cnt_o  <= cnt_i;
		if (swap) begin
			// take the carried entry, push the old one down the chain
			wt_q  <= wt_i;
			set_q <= set_i;
			wt_o  <= wt_q;
			set_o <= set_q;
		end else if (rd_hit) begin
			wt_o  <= wt_q;
			set_o <= set_q;
		end else begin
			wt_o  <= wt_i;
			set_o <= set_i;
		end
	end

endmodule

// ===== hdl/top_k_weighted_split_list_unit.sv =====
`timescale 1ns / 1ps

// Sorted list of the heaviest splits, largest weight first, ties in arrival order.
// Command channel: an item (operation, split_weight, taxon_set, read_rank) is taken
// at a clock edge with start high and busy low. busy stays low: every beat walks a
// chain of LIST_DEPTH cells, one cell per cycle, so a new item may enter every cycle
// and later beats see the list exactly as the earlier ones left it.
// Result channel: done is high for one cycle with entry_valid, entry_weight,
// entry_taxa, kept_new and occupancy; the receiver cannot hold it off.
// From the accepting edge to done an item passes the issue register, the
// chain of LIST_DEPTH cells and the result register. Results come out
// in item order, one per item. Throughput is one item per cycle.
// Configuration: cfg_data carries list_limit, written when cfg_valid is high;
// cfg_ready is always high. Write it only while no item is in flight.
// Reset: asynchronous, active low. The list comes up empty and list_limit is 256.
// Entry storage has no reset; entries are only read below the held count.
module top_k_weighted_split_list_unit import tkws_pkg::*; #(
	parameter int LIST_DEPTH = DEF_LIST_DEPTH,
	parameter int TAXA       = DEF_TAXA
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                operation,
	input  logic [WEIGHT_W-1:0] split_weight,
	input  logic [SET_W-1:0]    taxon_set,
	input  logic [RANK_W-1:0]   read_rank,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LIMIT_W-1:0]  cfg_data,
	output logic                done,
	output logic                entry_valid,
	output logic [WEIGHT_W-1:0] entry_weight,
	output logic [SET_W-1:0]    entry_taxa,
	output logic                kept_new,
	output logic [OCC_W-1:0]    occupancy
);

	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0]      cnt_q;
	logic               accept;
	logic [31:0]        lim_eff;
	logic               ovf;
	logic               rank_ok;
	ctl_t               issue_ctl;

	ctl_t                ctl   [0:LIST_DEPTH];
	logic [WEIGHT_W-1:0] wt    [0:LIST_DEPTH];
	logic [TAXA-1:0]     set   [0:LIST_DEPTH];
	logic [RANK_W-1:0]   rank  [0:LIST_DEPTH];
	logic [CW-1:0]       cnt   [0:LIST_DEPTH];

	ctl_t                tail;
	logic [31:0]         occ_after;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_comb begin
		lim_eff = (32'(limit_q) < 32'(LIST_DEPTH)) ? 32'(limit_q) : 32'(LIST_DEPTH);
		ovf     = (32'(cnt_q) + 32'd1) > lim_eff;
		rank_ok = 32'(read_rank) < 32'(cnt_q);
		issue_ctl = '0;
		if (accept) begin
			issue_ctl.vld   = 1'b1;
			issue_ctl.op    = operation;
			issue_ctl.fresh = 1'b1;
			issue_ctl.hit   = (operation == OP_INSERT) ? ovf : rank_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			cnt_q   <= '0;
			ctl[0]  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			ctl[0] <= issue_ctl;
			if (accept && operation == OP_INSERT && !ovf) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// issue register: count before the item rides with the beat
	always_ff @(posedge clk) begin
		if (accept) begin
			wt[0]   <= split_weight;
			set[0]  <= taxon_set[TAXA-1:0];
			rank[0] <= read_rank;
			cnt[0]  <= cnt_q;
		end
	end

	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
		tkws_cell #(
			.IDX  (g),
			.TAXA (TAXA),
			.CW   (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl[g]),
			.wt_i   (wt[g]),
			.set_i  (set[g]),
			.rank_i (rank[g]),
			.cnt_i  (cnt[g]),
			.ctl_o  (ctl[g+1]),
			.wt_o   (wt[g+1]),
			.set_o  (set[g+1]),
			.rank_o (rank[g+1]),
			.cnt_o  (cnt[g+1])
		);
	end

	always_comb begin
		tail      = ctl[LIST_DEPTH];
		occ_after = 32'(cnt[LIST_DEPTH]);
		if (tail.op == OP_INSERT && !tail.hit) begin
			occ_after = 32'(cnt[LIST_DEPTH]) + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		entry_valid  <= tail.hit;
		entry_weight <= tail.hit ? wt[LIST_DEPTH] : '0;
		entry_taxa   <= tail.hit ? SET_W'(set[LIST_DEPTH]) : '0;
		// drop the carried entry at the tail; it was the new one if never swapped
		kept_new     <= (tail.op == OP_INSERT) && (!tail.hit || !tail.fresh);
		occupancy    <= OCC_W'(occ_after);
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(LIST_DEPTH))
		else $error("entry count above list depth");

	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q >= $past(cnt_q))
		else $error("entry count went down");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(cnt_q))
		else $error("entry count moved without an item");

	a_drop_new: assert property (@(posedge clk) disable iff (!arst_n)
		done && !kept_new && !entry_valid |-> !$past(tail.op == OP_INSERT))
		else $error("insert lost its new entry without reporting a drop");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import tkws_pkg::*;

	localparam int LATENCY        = DEF_LIST_DEPTH + 2;
	localparam int WATCHDOG_LIMIT = 8 * LATENCY;
	localparam logic [SET_W-1:0] TAXA_MASK =
		(DEF_TAXA >= SET_W) ? '1 : ((64'd1 << DEF_TAXA) - 64'd1);

	typedef struct packed {
		logic                valid;
		logic [WEIGHT_W-1:0] weight;
		logic [SET_W-1:0]    taxa;
		logic                kept;
		logic [OCC_W-1:0]    occ;
	} split_result_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                busy;
	logic                operation    = OP_INSERT;
	logic [WEIGHT_W-1:0] split_weight = '0;
	logic [SET_W-1:0]    taxon_set    = '0;
	logic [RANK_W-1:0]   read_rank    = '0;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [LIMIT_W-1:0]  cfg_data     = '0;
	logic                done;
	logic                entry_valid;
	logic [WEIGHT_W-1:0] entry_weight;
	logic [SET_W-1:0]    entry_taxa;
	logic                kept_new;
	logic [OCC_W-1:0]    occupancy;

	// sorted list as the block should hold it
	logic [WEIGHT_W-1:0] held_weight [DEF_LIST_DEPTH];
	logic [SET_W-1:0]    held_taxa   [DEF_LIST_DEPTH];
	int                  held_count  = 0;
	int                  list_limit_now = LIMIT_RESET;

	split_result_t pending_results[$];
	int            mismatches  = 0;
	int            idle_cycles = 0;
	bit            gaps_on     = 1'b1;

	top_k_weighted_split_list_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.split_weight (split_weight),
		.taxon_set    (taxon_set),
		.read_rank    (read_rank),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.entry_valid  (entry_valid),
		.entry_weight (entry_weight),
		.entry_taxa   (entry_taxa),
		.kept_new     (kept_new),
		.occupancy    (occupancy)
	);

	always #5 clk = ~clk;

	function automatic split_result_t apply_split_item(input logic op,
			input logic [WEIGHT_W-1:0] w, input logic [SET_W-1:0] set_in,
			input logic [RANK_W-1:0] rank);
		split_result_t res;
		logic [SET_W-1:0] s;
		int cap;
		int pos;
		res = '0;
		s = set_in & TAXA_MASK;
		cap = (list_limit_now < DEF_LIST_DEPTH) ? list_limit_now : DEF_LIST_DEPTH;
		if (op == OP_INSERT) begin
			// equal weights stay ahead of the new entry
			pos = 0;
			while (pos < held_count && held_weight[pos] >= w)
				pos++;
			if (held_count + 1 > cap) begin
				res.valid = 1'b1;
				if (pos >= held_count) begin
					res.weight = w;
					res.taxa   = s;
				end else begin
					res.kept   = 1'b1;
					res.weight = held_weight[held_count-1];
					res.taxa   = held_taxa[held_count-1];
					for (int i = held_count - 1; i > pos; i--) begin
						held_weight[i] = held_weight[i-1];
						held_taxa[i]   = held_taxa[i-1];
					end
					held_weight[pos] = w;
					held_taxa[pos]   = s;
				end
			end else begin
				res.kept = 1'b1;
				for (int i = held_count; i > pos; i--) begin
					held_weight[i] = held_weight[i-1];
					held_taxa[i]   = held_taxa[i-1];
				end
				held_weight[pos] = w;
				held_taxa[pos]   = s;
				held_count++;
			end
		end else if (rank < held_count) begin
			res.valid  = 1'b1;
			res.weight = held_weight[rank];
			res.taxa   = held_taxa[rank];
		end
		res.occ = OCC_W'(held_count);
		return res;
	endfunction

	// sample at the edge: check results, predict accepted beats, track the limit
	always @(posedge clk) begin
		split_result_t got;
		split_result_t want;
		if (arst_n) begin
			idle_cycles++;
			if (done) begin
				idle_cycles = 0;
				got.valid  = entry_valid;
				got.weight = entry_weight;
				got.taxa   = entry_taxa;
				got.kept   = kept_new;
				got.occ    = occupancy;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: valid=%0b weight=%h taxa=%h kept=%0b occ=%0d",
							got.valid, got.weight, got.taxa, got.kept, got.occ);
				end else begin
					want = pending_results.pop_front();
					if (got.valid !== want.valid || got.weight !== want.weight ||
							got.taxa !== want.taxa || got.kept !== want.kept ||
							got.occ !== want.occ) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp valid=%0b weight=%h taxa=%h kept=%0b occ=%0d",
								want.valid, want.weight, want.taxa, want.kept, want.occ);
							$display("          got valid=%0b weight=%h taxa=%h kept=%0b occ=%0d",
								got.valid, got.weight, got.taxa, got.kept, got.occ);
						end
					end
				end
			end
			if (start && !busy) begin
				idle_cycles = 0;
				pending_results.push_back(apply_split_item(operation, split_weight,
					taxon_set, read_rank));
			end
			if (cfg_valid && cfg_ready) begin
				idle_cycles = 0;
				list_limit_now = cfg_data;
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_item(input logic op, input logic [WEIGHT_W-1:0] w,
			input logic [SET_W-1:0] s, input logic [RANK_W-1:0] rank);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start        <= 1'b1;
		operation    <= op;
		split_weight <= w;
		taxon_set    <= s;
		read_rank    <= rank;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain(input int settle);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_list_limit(input logic [LIMIT_W-1:0] value);
		drain(8);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [WEIGHT_W-1:0] random_weight();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return WEIGHT_W'($urandom_range(0, 7)) << 16;
			2: return WEIGHT_W'($urandom_range(0, 3));
			default: return 32'hFFFF_FFFF - WEIGHT_W'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic random_items(input int count_items);
		logic [RANK_W-1:0] rank;
		for (int n = 0; n < count_items; n++) begin
			if ($urandom_range(0, 1))
				rank = RANK_W'($urandom_range(0, 255));
			else
				rank = RANK_W'($urandom_range(0, held_count > 255 ? 255 : held_count));
			if ($urandom_range(0, 3) != 0)
				send_item(OP_INSERT, random_weight(), {$urandom, $urandom}, rank);
			else
				send_item(OP_READ, random_weight(), {$urandom, $urandom}, rank);
		end
	endtask

	// empty list with no room: every insert drops the new entry
	task automatic test_limit_zero();
		write_list_limit(9'd0);
		send_item(OP_INSERT, 32'hFFFF_FFFF, '1, 8'hFF);
		send_item(OP_INSERT, 32'h0000_0000, '0, 8'h00);
		send_item(OP_READ, 32'h0000_0000, '0, 8'h00);
	endtask

	// limit above depth, weight and taxa extremes, ties, reads in and out of range
	task automatic test_extremes_and_ties();
		write_list_limit(9'h1FF);
		send_item(OP_INSERT, 32'h0000_0000, '0, 8'h00);
		send_item(OP_INSERT, 32'hFFFF_FFFF, '1, 8'hFF);
		send_item(OP_INSERT, 32'h0001_0000, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00);
		send_item(OP_INSERT, 32'h0001_0000, 64'h5555_5555_5555_5555, 8'h00);
		send_item(OP_INSERT, 32'h0001_0000, 64'h0000_0000_0000_0001, 8'h00);
		for (int r = 0; r <= 5; r++)
			send_item(OP_READ, 32'h0000_0000, '0, RANK_W'(r));
		send_item(OP_READ, 32'h0000_0000, '0, 8'hFF);
		send_item(OP_READ, 32'hFFFF_FFFF, '1, 8'h02);
	endtask

	// limit below the held count: drop the last, or the new entry when lightest
	task automatic test_limit_lowered();
		write_list_limit(9'd2);
		send_item(OP_INSERT, 32'h0002_0000, 64'h8000_0000_0000_0000, 8'h00);
		send_item(OP_INSERT, 32'h0000_0000, 64'h0000_0000_FFFF_0000, 8'h00);
		send_item(OP_READ, 32'h0000_0000, '0, 8'h04);
	endtask

	task automatic test_random_full_list();
		write_list_limit(9'h1FF);
		random_items(400);
		write_list_limit(9'd256);
		random_items(150);
	endtask

	task automatic test_random_tiny_limits();
		write_list_limit(9'd1);
		random_items(150);
		write_list_limit(9'd0);
		random_items(100);
	endtask

	task automatic test_random_mid_limits();
		write_list_limit(LIMIT_W'($urandom_range(2, 255)));
		random_items(200);
		write_list_limit(9'd17);
		random_items(200);
	endtask

	task automatic test_random_no_idle();
		gaps_on = 1'b0;
		write_list_limit(9'd256);
		random_items(200);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_limit_zero();
		test_extremes_and_ties();
		test_limit_lowered();
		test_random_full_list();
		test_random_tiny_limits();
		test_random_mid_limits();
		test_random_no_idle();
		drain(LATENCY + 16);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tkws_pkg.sv
hdl/tkws_cell.sv
hdl/top_k_weighted_split_list_unit.sv
bench/testbench.sv
